/* src/i2c_master_register_access_assert.svh */
// Assertion macros shared by the I2C master RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef I2C_MASTER_REGISTER_ACCESS_ASSERT_SVH
`define I2C_MASTER_REGISTER_ACCESS_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define I2C_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define I2C_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define I2C_ASSERT(lbl, clk, rst_n, ante, cons, msg)
`define I2C_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

/* src/i2cm_pkg.sv */
// Types and constants for the I2C register-access master.
// No dependencies.
`timescale 1ns / 1ps

package i2cm_pkg;

  typedef enum logic [18:0] {
    PH_IDLE = 19'h00001,
    PH_S0   = 19'h00002,
    PH_S1   = 19'h00004,
    PH_S2   = 19'h00008,
    PH_B0   = 19'h00010,
    PH_B1   = 19'h00020,
    PH_B2   = 19'h00040,
    PH_A0   = 19'h00080,
    PH_A1   = 19'h00100,
    PH_A2   = 19'h00200,
    PH_A3   = 19'h00400,
    PH_R0   = 19'h00800,
    PH_R1   = 19'h01000,
    PH_K0   = 19'h02000,
    PH_K1   = 19'h04000,
    PH_K2   = 19'h08000,
    PH_P0   = 19'h10000,
    PH_P1   = 19'h20000,
    PH_P2   = 19'h40000
  } phase_e;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_PROBE = 2'd3
  } cmd_e;

  // which byte's ACK is pending
  typedef enum logic [1:0] {
    SEQ_ADDR = 2'd0,
    SEQ_REG  = 2'd1,
    SEQ_DATA = 2'd2
  } seq_e;

  typedef enum logic {
    REG_HALF_PERIOD = 1'b0,
    REG_ACK_TIMEOUT = 1'b1
  } reg_idx_e;

  localparam logic [15:0] HALF_PERIOD_RST = 16'd5;
  localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd250;
  localparam logic        RW_READ         = 1'b1;
  localparam logic        RW_WRITE        = 1'b0;

endpackage

/* src/i2c_master_register_access.sv */
// I2C master top level: APB config registers, bus phase FSM, result register.
// Depends on i2cm_pkg and i2c_master_register_access_assert.svh.
`timescale 1ns / 1ps

// Open-drain 7-bit I2C master for register write, multi-byte register read
// and address probe. Every input word is one bus timing tick carrying the
// sampled SDA level and, when idle, a command; every accepted word yields
// exactly one result word with the SCL/SDA drive levels, busy, done/status
// and any received byte. A word is taken each clock while the result
// register is empty or being drained, so the rate is one tick per cycle:
// the phase FSM and its tick counter update in the same cycle that loads
// the result register. Each bus phase lasts half_period ticks; an ACK wait
// ends on a low SDA sample or NACKs after ack_timeout + 1 high samples.
// Write half_period and ack_timeout over APB only while no transfer runs.

`include "i2c_master_register_access_assert.svh"

module i2c_master_register_access
  import i2cm_pkg::*;
#(
  parameter int PHASE_BITS = 16,
  parameter int LEN_BITS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB config
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // tick input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [6:0]  dev_addr_i,
  input  logic [7:0]  reg_addr_i,
  input  logic [7:0]  wdata_i,
  input  logic [15:0] read_len_i,
  input  logic        sda_in_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        scl_out_o,
  output logic        sda_out_o,
  output logic        busy_res_o,
  output logic        done_res_o,
  output logic        status_o,
  output logic [7:0]  rdata_o,
  output logic        rdata_valid_o,
  output logic        rdata_last_o
);

  localparam logic [32:0] PhaseCap = (33'd1 << PHASE_BITS) - 33'd1;

  // config registers
  logic [15:0] half_period_q;
  logic [7:0]  ack_timeout_q;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= HALF_PERIOD_RST;
      ack_timeout_q <= ACK_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (reg_idx_e'(paddr[2]))
        REG_HALF_PERIOD: half_period_q <= pwdata[15:0];
        REG_ACK_TIMEOUT: ack_timeout_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[2]))
      REG_HALF_PERIOD: prdata = {16'b0, half_period_q};
      REG_ACK_TIMEOUT: prdata = {24'b0, ack_timeout_q};
      default:         prdata = '0;
    endcase
  end

  // effective phase length: zero reads as one, saturate to counter range
  logic [PHASE_BITS-1:0] hold_len;
  always_comb begin
    if ({17'b0, half_period_q} > PhaseCap) begin
      hold_len = '1;
    end else if (half_period_q == 16'd0) begin
      hold_len = PHASE_BITS'(1);
    end else begin
      hold_len = PHASE_BITS'(half_period_q);
    end
  end

  // FSM state
  phase_e                phase_q, phase_d;
  seq_e                  seq_q, seq_d;
  cmd_e                  cmd_q, cmd_d;
  logic [2:0]            bit_idx_q, bit_idx_d;
  logic [7:0]            shift_q, shift_d;
  logic [PHASE_BITS-1:0] ticks_q, ticks_d;
  logic [7:0]            ack_wait_q, ack_wait_d;
  logic [LEN_BITS-1:0]   bytes_left_q, bytes_left_d;
  logic [6:0]            dev_q, dev_d;
  logic [7:0]            reg_q, reg_d;
  logic [7:0]            wbyte_q, wbyte_d;
  logic                  scl_q, scl_d;
  logic                  sda_q, sda_d;
  logic                  result_q, result_d;

  // phase transition request
  logic   go_en;
  phase_e go_ph;
  logic   go_scl, go_sda;

  logic       done_w, status_w, rvalid_w, rlast_w;
  logic [7:0] rdata_w;
  logic [7:0] sh_rx;
  logic [LEN_BITS-1:0] bl_dec;

  logic in_fire;
  logic out_valid_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign sh_rx  = {shift_q[6:0], sda_in_i};
  assign bl_dec = (bytes_left_q == '0) ? '0 : bytes_left_q - LEN_BITS'(1);

  always_comb begin
    phase_d      = phase_q;
    seq_d        = seq_q;
    cmd_d        = cmd_q;
    bit_idx_d    = bit_idx_q;
    shift_d      = shift_q;
    ticks_d      = ticks_q;
    ack_wait_d   = ack_wait_q;
    bytes_left_d = bytes_left_q;
    dev_d        = dev_q;
    reg_d        = reg_q;
    wbyte_d      = wbyte_q;
    scl_d        = scl_q;
    sda_d        = sda_q;
    result_d     = result_q;
    go_en        = 1'b0;
    go_ph        = PH_IDLE;
    go_scl       = 1'b1;
    go_sda       = 1'b1;
    done_w       = 1'b0;
    status_w     = 1'b0;
    rvalid_w     = 1'b0;
    rlast_w      = 1'b0;
    rdata_w      = 8'd0;

    if (phase_q == PH_IDLE) begin
      if (cmd_e'(cmd_i) != CMD_NONE) begin
        cmd_d        = cmd_e'(cmd_i);
        dev_d        = dev_addr_i;
        reg_d        = reg_addr_i;
        wbyte_d      = wdata_i;
        bytes_left_d = read_len_i[LEN_BITS-1:0];
        seq_d        = SEQ_ADDR;
        bit_idx_d    = 3'd0;
        result_d     = 1'b0;
        go_en        = 1'b1;
        go_ph        = PH_S0;
      end
    end else if (phase_q == PH_A2) begin
      if (!sda_in_i) begin
        go_en  = 1'b1;
        go_ph  = PH_A3;
        go_scl = 1'b0;
        go_sda = sda_q;
      end else if (ack_wait_q >= ack_timeout_q) begin
        result_d = 1'b1;
        go_en    = 1'b1;
        go_ph    = PH_P0;
        go_scl   = 1'b0;
        go_sda   = 1'b0;
      end else begin
        ack_wait_d = ack_wait_q + 8'd1;
      end
    end else begin
      ticks_d = ticks_q + PHASE_BITS'(1);
      if (ticks_d >= hold_len) begin
        go_en = 1'b1;
        case (phase_q)
          PH_S0: begin
            go_ph  = PH_S1;
            go_sda = 1'b0;
          end
          PH_S1: begin
            go_ph  = PH_S2;
            go_scl = 1'b0;
            go_sda = 1'b0;
          end
          PH_S2: begin
            // repeated START carries the read address
            if (seq_q == SEQ_ADDR) begin
              shift_d = {dev_q, RW_WRITE};
            end else begin
              shift_d = {dev_q, RW_READ};
              seq_d   = SEQ_DATA;
            end
            bit_idx_d = 3'd0;
            go_ph     = PH_B0;
            go_scl    = 1'b0;
            go_sda    = dev_q[6];
          end
          PH_B0: begin
            go_ph  = PH_B1;
            go_sda = sda_q;
          end
          PH_B1: begin
            go_ph  = PH_B2;
            go_scl = 1'b0;
            go_sda = sda_q;
          end
          PH_B2: begin
            shift_d = {shift_q[6:0], 1'b0};
            go_scl  = 1'b0;
            if (bit_idx_q == 3'd7) begin
              bit_idx_d = 3'd0;
              go_ph     = PH_A0;
            end else begin
              bit_idx_d = bit_idx_q + 3'd1;
              go_ph     = PH_B0;
              go_sda    = shift_q[6];
            end
          end
          PH_A0: go_ph = PH_A1;
          PH_A1: go_ph = PH_A2;
          PH_A3: begin
            if (cmd_q == CMD_PROBE) begin
              go_ph  = PH_P0;
              go_scl = 1'b0;
              go_sda = 1'b0;
            end else begin
              case (seq_q)
                SEQ_ADDR: begin
                  shift_d   = reg_q;
                  seq_d     = SEQ_REG;
                  bit_idx_d = 3'd0;
                  go_ph     = PH_B0;
                  go_scl    = 1'b0;
                  go_sda    = reg_q[7];
                end
                SEQ_REG: begin
                  if (cmd_q == CMD_WRITE) begin
                    shift_d   = wbyte_q;
                    seq_d     = SEQ_DATA;
                    bit_idx_d = 3'd0;
                    go_ph     = PH_B0;
                    go_scl    = 1'b0;
                    go_sda    = wbyte_q[7];
                  end else begin
                    go_ph = PH_S0;
                  end
                end
                default: begin
                  if (cmd_q == CMD_READ && bytes_left_q != '0) begin
                    bit_idx_d = 3'd0;
                    shift_d   = 8'd0;
                    go_ph     = PH_R0;
                  end else begin
                    go_ph  = PH_P0;
                    go_scl = 1'b0;
                    go_sda = 1'b0;
                  end
                end
              endcase
            end
          end
          PH_R0: begin
            // bit sampled at the end of SCL high
            shift_d = sh_rx;
            if (bit_idx_q == 3'd7) begin
              rvalid_w = 1'b1;
              rdata_w  = sh_rx;
              rlast_w  = (bytes_left_q == LEN_BITS'(1));
            end
            go_ph  = PH_R1;
            go_scl = 1'b0;
          end
          PH_R1: begin
            go_scl = 1'b0;
            if (bit_idx_q == 3'd7) begin
              bit_idx_d = 3'd0;
              go_ph     = PH_K0;
              go_sda    = (bytes_left_q == LEN_BITS'(1)); // NACK the last byte
            end else begin
              bit_idx_d = bit_idx_q + 3'd1;
              go_ph     = PH_R0;
              go_scl    = 1'b1;
            end
          end
          PH_K0: begin
            go_ph  = PH_K1;
            go_sda = sda_q;
          end
          PH_K1: begin
            go_ph  = PH_K2;
            go_scl = 1'b0;
            go_sda = sda_q;
          end
          PH_K2: begin
            bytes_left_d = bl_dec;
            if (bl_dec == '0) begin
              go_ph  = PH_P0;
              go_scl = 1'b0;
              go_sda = 1'b0;
            end else begin
              shift_d = 8'd0;
              go_ph   = PH_R0;
            end
          end
          PH_P0: begin
            go_ph  = PH_P1;
            go_sda = 1'b0;
          end
          PH_P1: go_ph = PH_P2;
          PH_P2: begin
            done_w   = 1'b1;
            status_w = result_q;
            go_ph    = PH_IDLE;
          end
          default: go_ph = PH_IDLE;
        endcase
      end
    end

    if (go_en) begin
      phase_d    = go_ph;
      scl_d      = go_scl;
      sda_d      = go_sda;
      ticks_d    = '0;
      ack_wait_d = 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      seq_q        <= SEQ_ADDR;
      cmd_q        <= CMD_NONE;
      bit_idx_q    <= 3'd0;
      shift_q      <= 8'd0;
      ticks_q      <= '0;
      ack_wait_q   <= 8'd0;
      bytes_left_q <= '0;
      dev_q        <= 7'd0;
      reg_q        <= 8'd0;
      wbyte_q      <= 8'd0;
      scl_q        <= 1'b1;
      sda_q        <= 1'b1;
      result_q     <= 1'b0;
    end else if (in_fire) begin
      phase_q      <= phase_d;
      seq_q        <= seq_d;
      cmd_q        <= cmd_d;
      bit_idx_q    <= bit_idx_d;
      shift_q      <= shift_d;
      ticks_q      <= ticks_d;
      ack_wait_q   <= ack_wait_d;
      bytes_left_q <= bytes_left_d;
      dev_q        <= dev_d;
      reg_q        <= reg_d;
      wbyte_q      <= wbyte_d;
      scl_q        <= scl_d;
      sda_q        <= sda_d;
      result_q     <= result_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      scl_out_o     <= scl_d;
      sda_out_o     <= sda_d;
      busy_res_o    <= (phase_d != PH_IDLE);
      done_res_o    <= done_w;
      status_o      <= status_w;
      rdata_o       <= rdata_w;
      rdata_valid_o <= rvalid_w;
      rdata_last_o  <= rlast_w;
    end
  end

  assign out_valid_o = out_valid_q;

  `I2C_ASSERT_NEXT(a_cmd_starts, clk_i, rst_ni, in_fire && phase_q == PH_IDLE && cmd_i != CMD_NONE, phase_q == PH_S0 && out_valid_o && busy_res_o, "command did not start a transfer")
  `I2C_ASSERT_NEXT(a_state_holds, clk_i, rst_ni, !in_fire, $stable(phase_q) && $stable(ticks_q), "FSM moved without an input word")
  `I2C_ASSERT(a_stall_blocks, clk_i, rst_ni, out_valid_q && !out_ready_i, !in_ready_o, "input taken over a stalled result")
  `I2C_ASSERT(a_idle_released, clk_i, rst_ni, phase_q == PH_IDLE, scl_q && sda_q, "bus not released while idle")

endmodule

/* test/i2c_master_register_access_tb.sv */
// Self-checking testbench for the I2C register-access master: ticks in, drive levels out.
// Depends on i2cm_pkg and the i2c_master_register_access RTL.
`timescale 1ns / 1ps

module i2c_master_register_access_tb;
  import i2cm_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;

  typedef struct packed {
    cmd_e        op;
    logic [6:0]  dev;
    logic [7:0]  regb;
    logic [7:0]  wbyte;
    logic [15:0] len;
    logic        sda;
  } tick_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic       status;
    logic [7:0] rdata;
    logic       rvalid;
    logic       rlast;
  } drive_t;

  typedef struct packed {
    phase_e      ph;
    logic [2:0]  bit_idx;
    logic [7:0]  shreg;
    logic [15:0] ticks;
    logic [7:0]  ack_cnt;
    logic [15:0] left;
    cmd_e        op;
    logic [6:0]  dev;
    logic [7:0]  regb;
    logic [7:0]  wbyte;
    logic        scl;
    logic        sda;
    logic        nack;
    seq_e        seq;
    logic [15:0] hp;
    logic [7:0]  ato;
  } bus_state_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  cmd_i = '0;
  logic [6:0]  dev_addr_i = '0;
  logic [7:0]  reg_addr_i = '0;
  logic [7:0]  wdata_i = '0;
  logic [15:0] read_len_i = '0;
  logic        sda_in_i = 1'b1;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        scl_out_o;
  logic        sda_out_o;
  logic        busy_res_o;
  logic        done_res_o;
  logic        status_o;
  logic [7:0]  rdata_o;
  logic        rdata_valid_o;
  logic        rdata_last_o;

  i2c_master_register_access u_dut (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o, .cmd_i, .dev_addr_i, .reg_addr_i, .wdata_i,
    .read_len_i, .sda_in_i,
    .out_valid_o, .out_ready_i, .scl_out_o, .sda_out_o, .busy_res_o,
    .done_res_o, .status_o, .rdata_o, .rdata_valid_o, .rdata_last_o
  );

  tick_t      tick_q[$];
  drive_t     drive_expect_q[$];
  tick_t      cur_tick;
  drive_t     step_res;
  drive_t     want;
  bus_state_t dut_model;   // advanced on every accepted word
  bus_state_t plan_model;  // advanced as words are queued, steers SDA
  int         err_cnt = 0;
  int         stall_cnt = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         pushed = 0;
  int         nack_at = -1;
  int         rx_mode = 0;
  int         ack_idx = 0;
  int         ack_hold = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void go(inout bus_state_t s, input phase_e p, input logic c,
                             input logic d);
    s.ph = p;
    s.scl = c;
    s.sda = d;
    s.ticks = '0;
    s.ack_cnt = '0;
  endfunction

  function automatic void shift_out(inout bus_state_t s);
    s.bit_idx = '0;
    go(s, PH_B0, 1'b0, s.shreg[7]);
  endfunction

  // One bus tick of the master: returns the drive levels after the tick.
  function automatic void i2c_bus_step(inout bus_state_t s, input tick_t t, output drive_t r);
    logic [15:0] hold;
    r = '0;
    hold = (s.hp == 16'd0) ? 16'd1 : s.hp;
    if (s.ph == PH_IDLE) begin
      if (t.op != CMD_NONE) begin
        s.op = t.op;
        s.dev = t.dev;
        s.regb = t.regb;
        s.wbyte = t.wbyte;
        s.left = t.len;
        s.seq = SEQ_ADDR;
        s.bit_idx = '0;
        s.nack = 1'b0;
        go(s, PH_S0, 1'b1, 1'b1);
      end
    end else if (s.ph == PH_A2) begin
      // ACK wait samples every tick, not on phase boundaries
      if (!t.sda) begin
        go(s, PH_A3, 1'b0, s.sda);
      end else if (s.ack_cnt >= s.ato) begin
        s.nack = 1'b1;
        go(s, PH_P0, 1'b0, 1'b0);
      end else begin
        s.ack_cnt = s.ack_cnt + 8'd1;
      end
    end else begin
      s.ticks = s.ticks + 16'd1;
      if (s.ticks >= hold) begin
        case (s.ph)
          PH_S0: go(s, PH_S1, 1'b1, 1'b0);
          PH_S1: go(s, PH_S2, 1'b0, 1'b0);
          PH_S2: begin
            if (s.seq == SEQ_ADDR) begin
              s.shreg = {s.dev, RW_WRITE};
            end else begin
              s.shreg = {s.dev, RW_READ};
              s.seq = SEQ_DATA;
            end
            shift_out(s);
          end
          PH_B0: go(s, PH_B1, 1'b1, s.sda);
          PH_B1: go(s, PH_B2, 1'b0, s.sda);
          PH_B2: begin
            s.shreg = s.shreg << 1;
            if (s.bit_idx == 3'd7) begin
              s.bit_idx = '0;
              go(s, PH_A0, 1'b0, 1'b1);
            end else begin
              s.bit_idx = s.bit_idx + 3'd1;
              go(s, PH_B0, 1'b0, s.shreg[7]);
            end
          end
          PH_A0: go(s, PH_A1, 1'b1, 1'b1);
          PH_A1: go(s, PH_A2, 1'b1, 1'b1);
          PH_A3: begin
            if (s.op == CMD_PROBE) begin
              go(s, PH_P0, 1'b0, 1'b0);
            end else if (s.seq == SEQ_ADDR) begin
              s.shreg = s.regb;
              s.seq = SEQ_REG;
              shift_out(s);
            end else if (s.seq == SEQ_REG) begin
              if (s.op == CMD_WRITE) begin
                s.shreg = s.wbyte;
                s.seq = SEQ_DATA;
                shift_out(s);
              end else begin
                go(s, PH_S0, 1'b1, 1'b1);  // repeated START
              end
            end else if (s.op == CMD_READ && s.left != 16'd0) begin
              s.bit_idx = '0;
              s.shreg = '0;
              go(s, PH_R0, 1'b1, 1'b1);
            end else begin
              go(s, PH_P0, 1'b0, 1'b0);
            end
          end
          PH_R0: begin
            s.shreg = {s.shreg[6:0], t.sda};
            if (s.bit_idx == 3'd7) begin
              r.rvalid = 1'b1;
              r.rdata = s.shreg;
              r.rlast = (s.left == 16'd1);
            end
            go(s, PH_R1, 1'b0, 1'b1);
          end
          PH_R1: begin
            if (s.bit_idx == 3'd7) begin
              s.bit_idx = '0;
              go(s, PH_K0, 1'b0, (s.left == 16'd1));  // NACK the last byte
            end else begin
              s.bit_idx = s.bit_idx + 3'd1;
              go(s, PH_R0, 1'b1, 1'b1);
            end
          end
          PH_K0: go(s, PH_K1, 1'b1, s.sda);
          PH_K1: go(s, PH_K2, 1'b0, s.sda);
          PH_K2: begin
            if (s.left != 16'd0) s.left = s.left - 16'd1;
            if (s.left == 16'd0) begin
              go(s, PH_P0, 1'b0, 1'b0);
            end else begin
              s.shreg = '0;
              go(s, PH_R0, 1'b1, 1'b1);
            end
          end
          PH_P0: go(s, PH_P1, 1'b1, 1'b0);
          PH_P1: go(s, PH_P2, 1'b1, 1'b1);
          PH_P2: begin
            r.done = 1'b1;
            r.status = s.nack;
            go(s, PH_IDLE, 1'b1, 1'b1);
          end
          default: go(s, PH_IDLE, 1'b1, 1'b1);
        endcase
      end
    end
    r.scl = s.scl;
    r.sda = s.sda;
    r.busy = (s.ph != PH_IDLE);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    $display("mismatch %s: got %0h exp %0h at %0t", what, got, exp_val, $realtime);
    err_cnt++;
  endtask

  // SDA as a slave would drive it for the tick about to be queued
  function automatic logic bus_sda();
    if (plan_model.ph == PH_A2) begin
      if (plan_model.ack_cnt == 8'd0) begin
        if (nack_at == ack_idx || (nack_at == -2 && $urandom_range(0, 99) < 12))
          ack_hold = 300;  // outlasts any timeout
        else if (nack_at == -2)
          ack_hold = $urandom_range(0, 3);
        else
          ack_hold = 0;
        ack_idx++;
      end
      return (plan_model.ack_cnt < ack_hold);
    end
    if (plan_model.ph == PH_R0 && rx_mode == 1) return plan_model.left[0];
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic tick_t noise_tick(input cmd_e op);
    tick_t t;
    t.op = op;
    t.dev = 7'($urandom);
    t.regb = 8'($urandom);
    t.wbyte = 8'($urandom);
    t.len = 16'($urandom);
    t.sda = bus_sda();
    return t;
  endfunction

  task automatic send_tick(input tick_t t);
    drive_t unused;
    tick_q.push_back(t);
    i2c_bus_step(plan_model, t, unused);
    pushed++;
  endtask

  // Issue one command and queue ticks until the bus is idle again.
  task automatic run_txn(input cmd_e op, input logic [6:0] dev, input logic [7:0] regb,
                         input logic [7:0] wbyte, input logic [15:0] len,
                         input int nack_sel, input int rx_sel);
    tick_t t;
    nack_at = nack_sel;
    rx_mode = rx_sel;
    ack_idx = 0;
    t.op = op;
    t.dev = dev;
    t.regb = regb;
    t.wbyte = wbyte;
    t.len = len;
    t.sda = 1'($urandom_range(0, 1));
    send_tick(t);
    // commands offered while busy must be ignored
    while (plan_model.ph != PH_IDLE) send_tick(noise_tick(cmd_e'($urandom_range(0, 3))));
    repeat ($urandom_range(0, 3)) send_tick(noise_tick(CMD_NONE));
  endtask

  task automatic wait_drained();
    while (tick_q.size() != 0 || in_valid_i || drive_expect_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic cfg_write(input reg_idx_e idx, input logic [31:0] val);
    logic [31:0] mask;
    mask = (idx == REG_HALF_PERIOD) ? 32'h0000_ffff : 32'h0000_00ff;
    wait_drained();
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_HALF_PERIOD) begin
      plan_model.hp = val[15:0];
      dut_model.hp = val[15:0];
    end else begin
      plan_model.ato = val[7:0];
      dut_model.ato = val[7:0];
    end
    // read back
    @(posedge clk_i);
    psel <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if ((prdata & mask) != (val & mask)) report_mismatch("readback", prdata & mask, val & mask);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // driver: presents queued tick words and predicts each accepted one
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        i2c_bus_step(dut_model, cur_tick, step_res);
        drive_expect_q.push_back(step_res);
      end
      if (!in_valid_i || in_ready_o) begin
        if (tick_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_tick = tick_q.pop_front();
          in_valid_i <= 1'b1;
          cmd_i <= cur_tick.op;
          dev_addr_i <= cur_tick.dev;
          reg_addr_i <= cur_tick.regb;
          wdata_i <= cur_tick.wbyte;
          read_len_i <= cur_tick.len;
          sda_in_i <= cur_tick.sda;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: checks result words, throttles ready, runs the watchdog
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_cnt <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (drive_expect_q.size() == 0) begin
          report_mismatch("unexpected word", 0, 0);
        end else begin
          want = drive_expect_q.pop_front();
          if (scl_out_o !== want.scl) report_mismatch("scl_out", scl_out_o, want.scl);
          if (sda_out_o !== want.sda) report_mismatch("sda_out", sda_out_o, want.sda);
          if (busy_res_o !== want.busy) report_mismatch("busy_res", busy_res_o, want.busy);
          if (done_res_o !== want.done) report_mismatch("done_res", done_res_o, want.done);
          if (status_o !== want.status) report_mismatch("status", status_o, want.status);
          if (rdata_o !== want.rdata) report_mismatch("rdata", rdata_o, want.rdata);
          if (rdata_valid_o !== want.rvalid)
            report_mismatch("rdata_valid", rdata_valid_o, want.rvalid);
          if (rdata_last_o !== want.rlast)
            report_mismatch("rdata_last", rdata_last_o, want.rlast);
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_cnt <= 0;
      end else if (stall_cnt >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        stall_cnt <= stall_cnt + 1;
      end
    end
  end

  initial begin
    int start;
    plan_model = '0;
    plan_model.ph = PH_IDLE;
    plan_model.op = CMD_NONE;
    plan_model.seq = SEQ_ADDR;
    plan_model.scl = 1'b1;
    plan_model.sda = 1'b1;
    plan_model.hp = HALF_PERIOD_RST;
    plan_model.ato = ACK_TIMEOUT_RST;
    dut_model = plan_model;
    send_idle_pct = 22;
    recv_idle_pct = 77;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset timing first
    run_txn(CMD_PROBE, 7'h7f, 8'h00, 8'h00, 16'd0, -1, 0);
    cfg_write(REG_HALF_PERIOD, 32'd1);
    cfg_write(REG_ACK_TIMEOUT, 32'd3);
    run_txn(CMD_WRITE, 7'h00, 8'h00, 8'hff, 16'hffff, -1, 0);
    run_txn(CMD_WRITE, 7'h55, 8'hff, 8'h00, 16'd0, 2, 0);   // data byte NACKed
    run_txn(CMD_READ, 7'h2a, 8'h80, 8'h00, 16'd0, -1, 0);   // zero-length read
    run_txn(CMD_READ, 7'h7f, 8'hff, 8'h00, 16'd1, -1, 1);
    run_txn(CMD_READ, 7'h01, 8'h01, 8'h00, 16'd2, -1, 1);   // 0x00 then 0xff
    run_txn(CMD_PROBE, 7'h12, 8'h00, 8'h00, 16'd0, 0, 0);   // address NACK
    run_txn(CMD_READ, 7'h33, 8'h44, 8'h00, 16'd3, 2, 0);    // read address NACK
    cfg_write(REG_ACK_TIMEOUT, 32'd0);
    run_txn(CMD_PROBE, 7'h40, 8'h00, 8'h00, 16'd0, -1, 0);
    run_txn(CMD_PROBE, 7'h41, 8'h00, 8'h00, 16'd0, 0, 0);
    cfg_write(REG_HALF_PERIOD, 32'd0);                     // behaves as 1
    cfg_write(REG_ACK_TIMEOUT, 32'd255);
    run_txn(CMD_PROBE, 7'h0f, 8'h00, 8'h00, 16'd0, 0, 0);
    run_txn(CMD_WRITE, 7'h70, 8'h5a, 8'ha5, 16'd0, -1, 0);
    cfg_write(REG_HALF_PERIOD, 32'd4);
    run_txn(CMD_PROBE, 7'h3c, 8'h00, 8'h00, 16'd0, -1, 0);
    cfg_write(REG_HALF_PERIOD, 32'd65535);
    repeat (6) send_tick(noise_tick(CMD_NONE));

    // random: three handshake pressure profiles, two timings each
    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 22 : (mode == 1) ? 77 : 0;
      recv_idle_pct = (mode == 0) ? 77 : (mode == 1) ? 22 : 0;
      for (int s = 0; s < 2; s++) begin
        cfg_write(REG_HALF_PERIOD, $urandom_range(1, 3));
        cfg_write(REG_ACK_TIMEOUT, (mode == 2 && s == 1) ? 255 : $urandom_range(0, 5));
        start = pushed;
        while (pushed - start < 60)
          run_txn(cmd_e'($urandom_range(1, 3)), 7'($urandom), 8'($urandom), 8'($urandom),
                  ($urandom_range(0, 9) == 0) ? 16'($urandom_range(4, 6)) :
                                                16'($urandom_range(0, 3)),
                  -2, 0);
      end
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
